>>> rtl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg
// shared types, command codes and helpers for the priority interrupt controller
// ----------------------------------------------------------------------------
`default_nettype none

package pic_pkg;

    localparam int LINES      = 8;
    localparam int LINE_W     = $clog2(LINES);
    localparam int INIT_WORDS = 5;
    localparam int STEP_W     = 3;

    // item kinds
    localparam logic [1:0] CMD_READ  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_RAISE = 2'd2;
    localparam logic [1:0] CMD_ACK   = 2'd3;

    // init sequence positions
    localparam logic [STEP_W-1:0] STEP_ICW1 = 3'd1;
    localparam logic [STEP_W-1:0] STEP_ICW2 = 3'd2;
    localparam logic [STEP_W-1:0] STEP_ICW3 = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ICW4 = 3'd4;
    localparam logic [STEP_W-1:0] STEP_DONE = 3'd5;

    // command word bits
    localparam logic [7:0] CW_INIT     = 8'h10;
    localparam logic [7:0] CW_OCW3_MSK = 8'h98;
    localparam logic [7:0] CW_OCW3_VAL = 8'h08;
    localparam logic [7:0] CW_EOI      = 8'h20;
    localparam logic [7:0] CW_RR       = 8'h02;
    localparam logic [7:0] ICW1_SINGLE = 8'h02;

    typedef struct packed {
        logic [1:0]        cmd;
        logic              port_a0;
        logic [7:0]        wdata;
        logic [LINE_W-1:0] irq_line;
    } pic_item_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic [7:0] vector;
        logic       vector_valid;
        logic       intr_pending;
    } pic_result_t;

    // index of the lowest set bit, zero when none
    function automatic logic [LINE_W-1:0] lowest_index(input logic [LINES-1:0] bits);
        logic [LINE_W-1:0] idx;
        idx = '0;
        for (int i = LINES - 1; i >= 0; i--)
        begin
            if (bits[i])
            begin
                idx = LINE_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

`default_nettype wire

>>> rtl/pic_core.sv
// ----------------------------------------------------------------------------
// pic_core
// controller registers and combinational result logic for one transaction
// ----------------------------------------------------------------------------
`default_nettype none

module pic_core (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  pic_pkg::pic_item_t   item,
    output pic_pkg::pic_result_t result
);
    import pic_pkg::*;

    logic [LINES-1:0]  request_reg, request_next;
    logic [LINES-1:0]  in_service_reg, in_service_next;
    logic [LINES-1:0]  mask_reg, mask_next;
    logic              read_isr_reg, read_isr_next;
    logic [STEP_W-1:0] init_step_reg, init_step_next;
    logic [7:0]        icw1_reg, icw1_next;
    logic [7:0]        icw2_reg, icw2_next;

    logic [LINES-1:0]  live;
    logic [LINES-1:0]  grant;
    logic [STEP_W-1:0] step_eff;

    assign live  = request_reg & ~mask_reg;
    assign grant = live & (~live + LINES'(1));

    // single mode skips icw3
    assign step_eff = (init_step_reg == STEP_ICW3 && (icw1_reg & ICW1_SINGLE) != 8'h00)
                      ? STEP_ICW4 : init_step_reg;

    always_comb
    begin
        request_next    = request_reg;
        in_service_next = in_service_reg;
        mask_next       = mask_reg;
        read_isr_next   = read_isr_reg;
        init_step_next  = init_step_reg;
        icw1_next       = icw1_reg;
        icw2_next       = icw2_reg;
        result          = '0;

        case (item.cmd)
            CMD_READ:
            begin
                if (item.port_a0)
                begin
                    result.rdata = mask_reg;
                end
                else
                begin
                    result.rdata = read_isr_reg ? in_service_reg : request_reg;
                end
            end
            CMD_WRITE:
            begin
                if (item.port_a0)
                begin
                    if (step_eff < STEP_DONE)
                    begin
                        if (step_eff == STEP_ICW1)
                        begin
                            icw1_next = item.wdata;
                        end
                        if (step_eff == STEP_ICW2)
                        begin
                            icw2_next = item.wdata;
                        end
                        init_step_next = step_eff + STEP_W'(1);
                    end
                    else
                    begin
                        mask_next = item.wdata;
                    end
                end
                else if ((item.wdata & CW_INIT) != 8'h00)
                begin
                    mask_next      = '0;
                    icw1_next      = item.wdata;
                    init_step_next = STEP_ICW2;
                end
                else
                begin
                    if ((item.wdata & CW_OCW3_MSK) == CW_OCW3_VAL
                        && (item.wdata & CW_RR) != 8'h00)
                    begin
                        read_isr_next = item.wdata[0];
                    end
                    // non-specific eoi drops the lowest in-service line
                    if ((item.wdata & CW_EOI) != 8'h00)
                    begin
                        in_service_next = in_service_reg & (in_service_reg - LINES'(1));
                    end
                end
            end
            CMD_RAISE:
            begin
                request_next = request_reg | (LINES'(1) << item.irq_line);
            end
            CMD_ACK:
            begin
                if (live != '0)
                begin
                    request_next        = request_reg & ~grant;
                    in_service_next     = in_service_reg | grant;
                    result.vector       = icw2_reg + {{(8-LINE_W){1'b0}}, lowest_index(live)};
                    result.vector_valid = 1'b1;
                end
            end
            default:
            begin
                result = '0;
            end
        endcase

        result.intr_pending = (request_next & ~mask_next) != '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            request_reg    <= '0;
            in_service_reg <= '0;
            mask_reg       <= '0;
            read_isr_reg   <= 1'b0;
            init_step_reg  <= '0;
            icw1_reg       <= '0;
            icw2_reg       <= '0;
        end
        else if (accept)
        begin
            request_reg    <= request_next;
            in_service_reg <= in_service_next;
            mask_reg       <= mask_next;
            read_isr_reg   <= read_isr_next;
            init_step_reg  <= init_step_next;
            icw1_reg       <= icw1_next;
            icw2_reg       <= icw2_next;
        end
    end

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        init_step_reg <= STEP_DONE)
        else $error("init step out of range");

    a_ack_in_service: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_ACK && live != '0)
        |=> (in_service_reg & $past(grant)) != '0 && (request_reg & $past(grant)) == '0)
        else $error("granted line not moved to in-service");

    a_raise_sets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && item.cmd == CMD_RAISE) |=> request_reg[$past(item.irq_line)])
        else $error("raised line not pending");

endmodule

`default_nettype wire

>>> rtl/pic_out_buf.sv
// ----------------------------------------------------------------------------
// pic_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
`default_nettype none

module pic_out_buf (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  accept,
    input  pic_pkg::pic_result_t result,
    output logic                 s_ready,
    output logic                 m_valid,
    input  wire                  m_ready,
    output pic_pkg::pic_result_t m_result
);
    import pic_pkg::*;

    logic        out_valid_reg;
    logic        skid_valid_reg;
    pic_result_t out_reg;
    pic_result_t skid_reg;
    logic        out_take;

    assign out_take = out_valid_reg && m_ready;
    assign s_ready  = !skid_valid_reg;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (out_take)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_ready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else
            begin
                out_valid_reg <= 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (out_take)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (accept)
        begin
            if (out_valid_reg && !m_ready)
            begin
                skid_reg <= result;
            end
            else
            begin
                out_reg <= result;
            end
        end
    end

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held with empty output register");

    a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && out_take) |=> out_valid_reg && !skid_valid_reg)
        else $error("skid entry not moved forward");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid && !m_ready) |=> m_valid && $stable(m_result))
        else $error("output transaction changed while stalled");

endmodule

`default_nettype wire

>>> rtl/priority_interrupt_controller.sv
// ----------------------------------------------------------------------------
// priority_interrupt_controller
// eight-line priority interrupt controller with stream input and output
// ----------------------------------------------------------------------------
// usage:
//   each input transaction is a port read, a port write, a line raise or an
//   interrupt acknowledge; each produces exactly one output transaction
//   carrying read data, the acknowledged vector and the pending flag.
//   all state updates in the cycle the input transaction is accepted, and each
//   result is registered in the output buffer and comes out in order.
//   throughput is one transaction per cycle while s_axis_tready is high; the
//   limit is the single update of the request / in-service / mask registers
//   per clock. a two-entry output buffer (output register plus skid register)
//   lets a new transaction in while a result is waiting; s_axis_tready drops
//   only when both entries hold results that the receiver has not taken.
//   reset clears the request, in-service and mask registers, the read select,
//   the init sequence and the stored init words, and empties the buffer.
// ----------------------------------------------------------------------------
`default_nettype none

module priority_interrupt_controller (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [15:0] s_axis_tdata,   // wdata[7:0], irq_line[10:8], zero pad
    input  wire  [2:0]  s_axis_tuser,   // cmd[1:0], port_a0[2]
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [23:0] m_axis_tdata,   // rdata[7:0], vector[15:8], intr_pending[16], pad
    output logic [0:0]  m_axis_tuser    // vector_valid[0]
);
    import pic_pkg::*;

    logic        accept;
    pic_item_t   item;
    pic_result_t result;
    pic_result_t m_result;

    assign accept        = s_axis_tvalid && s_axis_tready;
    assign item.cmd      = s_axis_tuser[1:0];
    assign item.port_a0  = s_axis_tuser[2];
    assign item.wdata    = s_axis_tdata[7:0];
    assign item.irq_line = s_axis_tdata[8 +: LINE_W];

    pic_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .result (result)
    );

    pic_out_buf u_out_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .result   (result),
        .s_ready  (s_axis_tready),
        .m_valid  (m_axis_tvalid),
        .m_ready  (m_axis_tready),
        .m_result (m_result)
    );

    assign m_axis_tdata = {7'b0, m_result.intr_pending, m_result.vector, m_result.rdata};
    assign m_axis_tuser = m_result.vector_valid;

endmodule

`default_nettype wire
